[design/h264rpc_pkg.sv]
// Shared types and constants for the H.264 RTP payload classifier.
// No dependencies; every other design file refers to it by scoped names.
package h264rpc_pkg;

  // Longest payload that is accepted, in bytes.
  localparam int unsigned MAX_PAYLOAD_BYTES = 4096;
  // The byte position saturates at MAX_PAYLOAD_BYTES + 1.
  localparam int unsigned POS_W  = $clog2(MAX_PAYLOAD_BYTES + 2);
  localparam int unsigned SIZE_W = 13;
  localparam int unsigned DIFF_W = (POS_W > SIZE_W) ? POS_W : SIZE_W;
  localparam int unsigned LEN_W  = 16;
  localparam int unsigned BYTE_W = 8;

  localparam logic [POS_W-1:0]  MAX_POS      = POS_W'(MAX_PAYLOAD_BYTES);
  localparam logic [POS_W-1:0]  MIN_STAP_POS = POS_W'(3);
  localparam logic [DIFF_W-1:0] SIZE_MAX     = DIFF_W'((1 << SIZE_W) - 1);
  localparam logic [DIFF_W-1:0] FU_HDR_BYTES = DIFF_W'(2);

  // NAL unit type codes (low five bits of a NAL or FU header).
  localparam logic [4:0] TYPE_FUA   = 5'd28;
  localparam logic [4:0] TYPE_STAPA = 5'd24;
  localparam logic [4:0] TYPE_IDR   = 5'd5;
  localparam logic [7:0] FNRI_MASK  = 8'hE0;
  localparam int unsigned START_BIT = 7;

  localparam logic [1:0] FUA_DATA_OFFSET = 2'd2;

  typedef enum logic [1:0] {
    KIND_SINGLE = 2'd0,
    KIND_STAPA  = 2'd1,
    KIND_FUA    = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    PH_FIRST     = 3'd0,
    PH_FU_HDR    = 3'd1,
    PH_FU_DATA   = 3'd2,
    PH_SINGLE    = 3'd3,
    PH_LEN_HI    = 3'd4,
    PH_LEN_LO    = 3'd5,
    PH_UNIT_HEAD = 3'd6,
    PH_UNIT_BODY = 3'd7
  } phase_e;

  typedef struct packed {
    logic [BYTE_W-1:0] payload_byte;
    logic              last_byte;
    logic              empty_payload;
  } in_item_t;

  typedef struct packed {
    logic              accepted;
    kind_e             packet_kind;
    logic              key_frame;
    logic              first_in_frame;
    logic              has_rebuilt_header;
    logic [BYTE_W-1:0] rebuilt_header;
    logic [1:0]        data_offset;
    logic [SIZE_W-1:0] data_size;
  } result_t;

endpackage

[design/h264rpc_in_reg.sv]
// Input register stage of the classifier: holds one accepted item.
// Depends on h264rpc_pkg for the item type.
module h264rpc_in_reg (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  output logic                  ready_o,
  input  h264rpc_pkg::in_item_t item_i,
  output logic                  valid_o,
  input  logic                  advance_i,
  output h264rpc_pkg::in_item_t item_o
);

  logic                  valid_q;
  h264rpc_pkg::in_item_t item_q;

  assign ready_o = !valid_q || advance_i;
  assign valid_o = valid_q;
  assign item_o  = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      item_q <= item_i;
    end
  end

endmodule

[design/h264rpc_parser.sv]
// Per-byte parse state and end-of-payload verdict logic.
// Depends on h264rpc_pkg for phases, codes and the result type.
module h264rpc_parser (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_i,
  input  h264rpc_pkg::in_item_t item_i,
  output logic                  has_result_o,
  output h264rpc_pkg::result_t  result_o
);

  logic [h264rpc_pkg::POS_W-1:0]  pos_q, pos_d;
  h264rpc_pkg::phase_e            phase_q, phase_d;
  logic [h264rpc_pkg::LEN_W-1:0]  left_q, left_d;
  logic [h264rpc_pkg::BYTE_W-1:0] len_hi_q, len_hi_d;
  logic [h264rpc_pkg::BYTE_W-1:0] ind_q, ind_d;
  logic [h264rpc_pkg::BYTE_W-1:0] fu_q, fu_d;
  logic                           err_q, err_d;

  logic [h264rpc_pkg::DIFF_W-1:0] diff;
  logic                           ok;
  logic [4:0]                     byte_type;

  assign has_result_o = item_i.last_byte || item_i.empty_payload;
  assign byte_type    = item_i.payload_byte[4:0];

  // Next parse state for the byte in hand.
  always_comb begin
    pos_d    = pos_q;
    phase_d  = phase_q;
    left_d   = left_q;
    len_hi_d = len_hi_q;
    ind_d    = ind_q;
    fu_d     = fu_q;
    err_d    = err_q;
    if (!item_i.empty_payload) begin
      if (pos_q <= h264rpc_pkg::MAX_POS) begin
        pos_d = pos_q + 1'b1;
      end
      if (pos_d > h264rpc_pkg::MAX_POS) begin
        err_d = 1'b1;
      end
      case (phase_q)
        h264rpc_pkg::PH_FIRST: begin
          ind_d = item_i.payload_byte;
          if (byte_type == h264rpc_pkg::TYPE_FUA) begin
            phase_d = h264rpc_pkg::PH_FU_HDR;
          end else if (byte_type == h264rpc_pkg::TYPE_STAPA) begin
            phase_d = h264rpc_pkg::PH_LEN_HI;
          end else begin
            phase_d = h264rpc_pkg::PH_SINGLE;
          end
        end
        h264rpc_pkg::PH_FU_HDR: begin
          fu_d    = item_i.payload_byte;
          phase_d = h264rpc_pkg::PH_FU_DATA;
        end
        h264rpc_pkg::PH_LEN_HI: begin
          len_hi_d = item_i.payload_byte;
          phase_d  = h264rpc_pkg::PH_LEN_LO;
        end
        h264rpc_pkg::PH_LEN_LO: begin
          left_d = {len_hi_q, item_i.payload_byte};
          if (left_d == '0) begin
            err_d   = 1'b1;
            phase_d = h264rpc_pkg::PH_LEN_HI;
          end else begin
            phase_d = h264rpc_pkg::PH_UNIT_HEAD;
          end
        end
        h264rpc_pkg::PH_UNIT_HEAD, h264rpc_pkg::PH_UNIT_BODY: begin
          // Nested aggregates and fragments are not allowed inside a STAP-A.
          if (phase_q == h264rpc_pkg::PH_UNIT_HEAD &&
              (byte_type inside {h264rpc_pkg::TYPE_STAPA, h264rpc_pkg::TYPE_FUA})) begin
            err_d = 1'b1;
          end
          if (left_q != '0) begin
            left_d = left_q - 1'b1;
          end
          phase_d = (left_d == '0) ? h264rpc_pkg::PH_LEN_HI : h264rpc_pkg::PH_UNIT_BODY;
        end
        default: begin
        end
      endcase
    end
  end

  // Verdict on the state after this byte.
  always_comb begin
    result_o = '0;
    ok       = 1'b0;
    diff     = h264rpc_pkg::DIFF_W'(pos_d) - h264rpc_pkg::FU_HDR_BYTES;
    case (phase_d)
      h264rpc_pkg::PH_FU_DATA: ok = 1'b1;
      h264rpc_pkg::PH_SINGLE:  ok = 1'b1;
      h264rpc_pkg::PH_LEN_HI:  ok = pos_d > h264rpc_pkg::MIN_STAP_POS;
      default:                 ok = 1'b0;
    endcase
    if (ok && !err_d) begin
      result_o.accepted = 1'b1;
      case (phase_d)
        h264rpc_pkg::PH_FU_DATA: begin
          result_o.packet_kind        = h264rpc_pkg::KIND_FUA;
          result_o.key_frame          = (fu_d[4:0] == h264rpc_pkg::TYPE_IDR);
          result_o.first_in_frame     = fu_d[h264rpc_pkg::START_BIT];
          result_o.has_rebuilt_header = fu_d[h264rpc_pkg::START_BIT];
          if (fu_d[h264rpc_pkg::START_BIT]) begin
            result_o.rebuilt_header = (ind_d & h264rpc_pkg::FNRI_MASK) | {3'b000, fu_d[4:0]};
          end
          result_o.data_offset = h264rpc_pkg::FUA_DATA_OFFSET;
          result_o.data_size   = (diff > h264rpc_pkg::SIZE_MAX) ? '1 :
                                 diff[h264rpc_pkg::SIZE_W-1:0];
        end
        h264rpc_pkg::PH_LEN_HI: result_o.packet_kind = h264rpc_pkg::KIND_STAPA;
        default:                result_o.packet_kind = h264rpc_pkg::KIND_SINGLE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      phase_q  <= h264rpc_pkg::PH_FIRST;
      left_q   <= '0;
      len_hi_q <= '0;
      ind_q    <= '0;
      fu_q     <= '0;
      err_q    <= 1'b0;
    end else if (step_i) begin
      if (has_result_o) begin
        // Payload ends: return to the idle parse state.
        pos_q    <= '0;
        phase_q  <= h264rpc_pkg::PH_FIRST;
        left_q   <= '0;
        len_hi_q <= '0;
        ind_q    <= '0;
        fu_q     <= '0;
        err_q    <= 1'b0;
      end else begin
        pos_q    <= pos_d;
        phase_q  <= phase_d;
        left_q   <= left_d;
        len_hi_q <= len_hi_d;
        ind_q    <= ind_d;
        fu_q     <= fu_d;
        err_q    <= err_d;
      end
    end
  end

endmodule

[design/h264rpc_out_reg.sv]
// Result register: holds one verdict until the downstream side takes it.
// Depends on h264rpc_pkg for the result type.
module h264rpc_out_reg (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 load_i,
  input  h264rpc_pkg::result_t result_i,
  output logic                 free_o,
  output logic                 valid_o,
  input  logic                 ready_i,
  output h264rpc_pkg::result_t result_o
);

  logic                 valid_q;
  h264rpc_pkg::result_t result_q;

  assign free_o   = !valid_q || ready_i;
  assign valid_o  = valid_q;
  assign result_o = result_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (free_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && free_o) begin
      result_q <= result_i;
    end
  end

endmodule

[design/h264_rtp_payload_classifier_unit.sv]
// Timing: the last item of a payload is registered in the input register and
//   judged from it straight into the result register, which drives the master
//   side; a full result register holds the item back in the input register.
// Throughput: one payload byte per cycle; items that end no payload keep
//   moving while a verdict waits, and the input stalls only on a second verdict.
// Reset: rst_ni clears the parse state and both valid flags asynchronously.
module h264_rtp_payload_classifier_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,  // [7:0] payload_byte
  input  logic        s_axis_tlast_i,  // last_byte
  input  logic        s_axis_tuser_i,  // [0] empty_payload
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [0] accepted, [1] key_frame, [2] first_in_frame, [3] has_rebuilt_header,
  // [11:4] rebuilt_header, [13:12] data_offset, [26:14] data_size, [31:27] zero
  output logic [31:0] m_axis_tdata_o,
  output logic [1:0]  m_axis_tuser_o   // [1:0] packet_kind
);

  h264rpc_pkg::in_item_t in_item, held_item;
  h264rpc_pkg::result_t  verdict, out_result;
  logic                  held_valid;
  logic                  has_result;
  logic                  out_free;
  logic                  advance;

  assign in_item.payload_byte  = s_axis_tdata_i;
  assign in_item.last_byte     = s_axis_tlast_i;
  assign in_item.empty_payload = s_axis_tuser_i;

  // Move the held item on when it makes no verdict or the result register has room.
  assign advance = held_valid && (!has_result || out_free);

  h264rpc_in_reg u_in_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (s_axis_tvalid_i),
    .ready_o   (s_axis_tready_o),
    .item_i    (in_item),
    .valid_o   (held_valid),
    .advance_i (advance),
    .item_o    (held_item)
  );

  h264rpc_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (advance),
    .item_i       (held_item),
    .has_result_o (has_result),
    .result_o     (verdict)
  );

  h264rpc_out_reg u_out_reg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (advance && has_result),
    .result_i (verdict),
    .free_o   (out_free),
    .valid_o  (m_axis_tvalid_o),
    .ready_i  (m_axis_tready_i),
    .result_o (out_result)
  );

  // Pack the verdict onto the master side.
  assign m_axis_tdata_o = {5'b00000,
                           out_result.data_size,
                           out_result.data_offset,
                           out_result.rebuilt_header,
                           out_result.has_rebuilt_header,
                           out_result.first_in_frame,
                           out_result.key_frame,
                           out_result.accepted};
  assign m_axis_tuser_o = out_result.packet_kind;

endmodule

[design/h264rpc_checker.sv]
// Port-level checks for the classifier top level, bound in below.
// Depends on h264rpc_pkg for kind codes and the FU-A data offset.
module h264rpc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [31:0] m_axis_tdata_o,
  input logic [1:0]  m_axis_tuser_o
);

  // A stalled verdict stays offered.
  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("verdict dropped while stalled");

  // A rejected payload reports nothing else.
  a_reject_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tdata_o[0] |-> m_axis_tdata_o == '0 && m_axis_tuser_o == '0)
    else $error("rejected verdict carries nonzero fields");

  // FU-A specific fields appear only on FU-A verdicts, with the fixed offset.
  a_fua_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o != h264rpc_pkg::KIND_FUA |->
      m_axis_tdata_o[31:1] == '0)
    else $error("FU-A field set on a non FU-A verdict");

  a_fua_offset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o == h264rpc_pkg::KIND_FUA |->
      m_axis_tdata_o[13:12] == h264rpc_pkg::FUA_DATA_OFFSET &&
      m_axis_tdata_o[3] == m_axis_tdata_o[2] && m_axis_tdata_o[0])
    else $error("FU-A verdict inconsistent");

  a_kind_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tuser_o == h264rpc_pkg::KIND_SINGLE ||
      m_axis_tuser_o == h264rpc_pkg::KIND_STAPA || m_axis_tuser_o == h264rpc_pkg::KIND_FUA)
    else $error("unknown packet kind");

endmodule

bind h264_rtp_payload_classifier_unit h264rpc_checker u_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);
